// ===== hdl/mteu_pkg.sv =====
package mteu_pkg;

   localparam int NUM_MOTORS  = 8;
   localparam int SLOT_W      = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W  = 4;

   localparam logic [10:0] RST_BASE_ID         = 11'h201;
   localparam logic [15:0] RST_COUNTS_PER_TURN = 16'd8192;
   localparam logic [15:0] RST_ANGLE_SCALE     = 16'd2880;

   localparam logic [1:0] REG_BASE_ID         = 2'd0;
   localparam logic [1:0] REG_COUNTS_PER_TURN = 2'd1;
   localparam logic [1:0] REG_ANGLE_SCALE     = 2'd2;

   typedef struct packed {
      logic [10:0]        frame_id;
      logic [15:0]        encoder_raw;
      logic signed [15:0] speed_raw;
      logic [7:0]         temp_raw;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         motor_slot;
      logic signed [31:0] total_count;
      logic signed [47:0] angle_q16;
      logic signed [15:0] speed;
      logic [7:0]         temperature;
   } rsp_word_type;

   typedef struct packed {
      logic [10:0] base_id;
      logic [15:0] counts_per_turn;
      logic [15:0] angle_scale;
   } cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      logic [15:0]        count;
      logic signed [15:0] speed;
      logic [7:0]         temperature;
   } item_type;

endpackage

// ===== hdl/mteu_front.sv =====
module mteu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  mteu_pkg::req_word_type req_word,
   input  logic [10:0]           base_id,
   output logic                  item_valid,
   output mteu_pkg::item_type    item,
   input  logic                  queue_full
);
   import mteu_pkg::*;

   logic        valid_ff, valid_in;
   item_type    item_ff;
   logic [10:0] offset;
   logic        in_range;
   logic        accept;
   logic        moved;

   assign offset   = req_word.frame_id - base_id;
   assign in_range = (req_word.frame_id >= base_id) && (offset < 11'(NUM_MOTORS));

   assign moved    = valid_ff && !queue_full;
   assign req_full = valid_ff && queue_full;
   assign accept   = req_push && !req_full;

   // out-of-range identifiers are dropped here
   always_comb begin
      valid_in = valid_ff && !moved;
      if (accept) begin
         valid_in = in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff.slot        <= offset[SLOT_W-1:0];
         item_ff.count       <= req_word.encoder_raw;
         item_ff.speed       <= req_word.speed_raw;
         item_ff.temperature <= req_word.temp_raw;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hdl/mteu_queue.sv =====
module mteu_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mteu_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output mteu_pkg::item_type head_item
);
   import mteu_pkg::*;

   item_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && valid;
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/mteu_back.sv =====
module mteu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  mteu_pkg::item_type     item,
   output logic                   item_pop,
   input  mteu_pkg::cfg_type      cfg,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output mteu_pkg::rsp_word_type rsp_word
);
   import mteu_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UNWRAP,
      ST_TOTAL,
      ST_ANGLE
   } state_type;

   state_type          state_ff;
   item_type           item_ff;
   logic [15:0]        last_count_ff [NUM_MOTORS];
   logic [15:0]        turn_count_ff [NUM_MOTORS];
   logic signed [15:0] turns_ff;
   logic signed [31:0] total_ff;
   logic               out_valid_ff;
   rsp_word_type       out_word_ff;

   logic signed [15:0] delta;
   logic signed [16:0] half;
   logic [15:0]        turn_in;
   logic signed [32:0] turn_prod;
   logic signed [31:0] total_in;
   logic signed [48:0] angle_prod;
   logic               out_free;
   logic               out_load;

   assign item_pop = (state_ff == ST_IDLE) && item_valid;
   assign out_free = !out_valid_ff || rsp_pop;
   assign out_load = (state_ff == ST_ANGLE) && out_free;

   // jump measured modulo one 16-bit wrap
   assign delta = $signed(item_ff.count - last_count_ff[item_ff.slot]);
   assign half  = $signed({2'b00, cfg.counts_per_turn[15:1]});

   always_comb begin
      turn_in = turn_count_ff[item_ff.slot];
      if (17'(delta) < -half) begin
         turn_in = turn_count_ff[item_ff.slot] + 16'd1;
      end else if (17'(delta) > half) begin
         turn_in = turn_count_ff[item_ff.slot] - 16'd1;
      end
   end

   assign turn_prod  = turns_ff * $signed({1'b0, cfg.counts_per_turn});
   assign total_in   = 32'(turn_prod + 33'($signed(item_ff.count)));
   assign angle_prod = total_ff * $signed({1'b0, cfg.angle_scale});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_MOTORS; i++) begin
            last_count_ff[i] <= '0;
            turn_count_ff[i] <= '0;
         end
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop && out_valid_ff) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (item_valid) begin
                  item_ff  <= item;
                  state_ff <= ST_UNWRAP;
               end
            end
            ST_UNWRAP: begin
               last_count_ff[item_ff.slot] <= item_ff.count;
               turn_count_ff[item_ff.slot] <= turn_in;
               turns_ff <= $signed(turn_in);
               state_ff <= ST_TOTAL;
            end
            ST_TOTAL: begin
               total_ff <= total_in;
               state_ff <= ST_ANGLE;
            end
            ST_ANGLE: begin
               if (out_free) begin
                  out_word_ff.motor_slot  <= 3'(item_ff.slot);
                  out_word_ff.total_count <= total_ff;
                  out_word_ff.angle_q16   <= angle_prod[47:0];
                  out_word_ff.speed       <= item_ff.speed;
                  out_word_ff.temperature <= item_ff.temperature;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_word  = out_word_ff;

endmodule

// ===== hdl/multi_turn_encoder_unwrap_top.sv =====
// Multi-turn position unwrap for a bank of motors. Each pushed word is one decoded
// feedback frame; frames whose identifier falls in base_id .. base_id+NUM_MOTORS-1
// update that slot's last count and 16-bit turn counter (a jump of more than half a
// turn moves the counter by one) and give one result word with the total count,
// total times angle_scale in Q16, and speed and temperature passed through. Other
// identifiers give no result. A front stage checks the identifier and feeds a
// two-word queue. The back end fetches a word, unwraps and updates state, forms
// turns times counts_per_turn, then total times angle_scale, and takes no new word
// until that result is loaded, waiting while a result is unread. Registers: base_id
// at 0x0, counts_per_turn at 0x4, angle_scale at 0x8; write them only while idle.
module multi_turn_encoder_unwrap_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  mteu_pkg::req_word_type           req_word,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output mteu_pkg::rsp_word_type           rsp_word,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mteu_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import mteu_pkg::*;

   cfg_type     cfg_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   logic        front_valid;
   item_type    front_item;
   logic        queue_full;
   logic        queue_valid;
   item_type    queue_item;
   logic        queue_pop;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_id         <= RST_BASE_ID;
         cfg_ff.counts_per_turn <= RST_COUNTS_PER_TURN;
         cfg_ff.angle_scale     <= RST_ANGLE_SCALE;
      end else if (csr_write) begin
         case (csr_index)
            REG_BASE_ID:         cfg_ff.base_id         <= csr_pwdata[10:0];
            REG_COUNTS_PER_TURN: cfg_ff.counts_per_turn <= csr_pwdata[15:0];
            REG_ANGLE_SCALE:     cfg_ff.angle_scale     <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_BASE_ID:         csr_prdata = {21'd0, cfg_ff.base_id};
         REG_COUNTS_PER_TURN: csr_prdata = {16'd0, cfg_ff.counts_per_turn};
         REG_ANGLE_SCALE:     csr_prdata = {16'd0, cfg_ff.angle_scale};
         default:             csr_prdata = '0;
      endcase
   end

   mteu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_word   (req_word),
      .base_id    (cfg_ff.base_id),
      .item_valid (front_valid),
      .item       (front_item),
      .queue_full (queue_full)
   );

   mteu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .head_item (queue_item)
   );

   mteu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_valid),
      .item       (queue_item),
      .item_pop   (queue_pop),
      .cfg        (cfg_ff),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_word   (rsp_word)
   );

endmodule
